[design/tsof_pkg.sv]
// ----------------------------------------------------------------------------
// tsof_pkg
// Shared types and constants for the TCP timestamp option finder.
// ----------------------------------------------------------------------------
package tsof_pkg;

	// option kinds and lengths
	localparam logic [7:0] KIND_EOL    = 8'd0;
	localparam logic [7:0] KIND_NOP    = 8'd1;
	localparam logic [7:0] KIND_TSTAMP = 8'd8;
	localparam logic [7:0] LEN_TSTAMP  = 8'd10;
	localparam logic [7:0] HDR_BYTES   = 8'd2;

	// verdict codes
	typedef enum logic [1:0] {
		ST_FOUND   = 2'd0,
		ST_NONE    = 2'd1,
		ST_CUT     = 2'd2,
		ST_BAD_LEN = 2'd3
	} status_t;

	// parse phase, one-hot
	typedef enum logic [2:0] {
		PH_KIND = 3'b001,
		PH_LEN  = 3'b010,
		PH_BODY = 3'b100
	} phase_t;

	typedef logic [31:0] stamp_t;

endpackage

[design/tcp_timestamp_option_finder_unit.sv]
// ----------------------------------------------------------------------------
// tcp_timestamp_option_finder_unit
// Walks a TCP options area byte by byte and reports the timestamp option.
// ----------------------------------------------------------------------------
// One options byte is taken per cycle, with last_byte marking the end of the
// area. Each byte enters an input register; the parse state and the verdict
// register are updated from it, so the block takes one byte every cycle
// unless in_stall holds it back. Every area gets exactly one verdict: found
// with TSval and TSecr, not found, area cut before a length byte, or bad
// length. Bytes after the verdict are dropped up to the last byte. Throughput
// drops only while a verdict waits on out_stall with the input register also
// full.
module tcp_timestamp_option_finder_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [7:0]              opt_byte,
	input  logic                    last_byte,
	output logic                    out_valid,
	input  logic                    out_stall,
	output tsof_pkg::status_t       status,
	output tsof_pkg::stamp_t        ts_value,
	output tsof_pkg::stamp_t        ts_echo
);
	import tsof_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// parse state
	phase_t      phase_q;
	logic [7:0]  left_q;
	logic        capt_q;
	logic [63:0] stamps_q;
	logic        verdict_q;

	// result register
	logic    res_valid_q;
	status_t res_status_q;
	stamp_t  res_val_q;
	stamp_t  res_ecr_q;

	// next-state and result logic
	phase_t      phase_d;
	logic [7:0]  left_d;
	logic        capt_d;
	logic [63:0] stamps_d;
	logic        verdict_d;
	logic        emit;
	status_t     emit_status;
	logic [63:0] shifted;
	logic [7:0]  left_dec;
	logic        advance;
	logic        load_s1;

	// pipeline moves when the result register is free or being drained
	assign advance  = !res_valid_q || !out_stall;
	// input register loads when it is empty or its item moves on
	assign load_s1  = advance || !valid_s1;
	assign in_stall = !load_s1;

	assign shifted  = {stamps_q[55:0], byte_s1};
	assign left_dec = (left_q != 8'd0) ? left_q - 8'd1 : left_q;

	always_comb begin
		phase_d     = phase_q;
		left_d      = left_q;
		capt_d      = capt_q;
		stamps_d    = stamps_q;
		verdict_d   = verdict_q;
		emit        = 1'b0;
		emit_status = ST_NONE;
		if (!verdict_q) begin
			case (phase_q)
				PH_LEN: begin
					if (byte_s1 < HDR_BYTES) begin
						emit        = 1'b1;
						emit_status = ST_BAD_LEN;
					end else if (byte_s1 == HDR_BYTES) begin
						phase_d = PH_KIND;
						capt_d  = 1'b0;
						if (last_s1) begin
							emit        = 1'b1;
							emit_status = ST_NONE;
						end
					end else if (last_s1) begin
						emit        = 1'b1;
						emit_status = ST_BAD_LEN;
					end else begin
						left_d   = byte_s1 - HDR_BYTES;
						capt_d   = capt_q && (byte_s1 == LEN_TSTAMP);
						stamps_d = '0;
						phase_d  = PH_BODY;
					end
				end
				PH_BODY: begin
					stamps_d = shifted;
					left_d   = left_dec;
					if (left_dec == 8'd0) begin
						phase_d = PH_KIND;
						capt_d  = 1'b0;
						if (capt_q) begin
							emit        = 1'b1;
							emit_status = ST_FOUND;
						end else if (last_s1) begin
							emit        = 1'b1;
							emit_status = ST_NONE;
						end
					end else if (last_s1) begin
						emit        = 1'b1;
						emit_status = ST_BAD_LEN;
					end
				end
				default: begin
					// kind byte, also for any unused phase code
					if (byte_s1 == KIND_EOL) begin
						emit        = 1'b1;
						emit_status = ST_NONE;
					end else if (byte_s1 == KIND_NOP) begin
						if (last_s1) begin
							emit        = 1'b1;
							emit_status = ST_NONE;
						end
					end else if (last_s1) begin
						emit        = 1'b1;
						emit_status = ST_CUT;
					end else begin
						capt_d  = (byte_s1 == KIND_TSTAMP);
						phase_d = PH_LEN;
					end
				end
			endcase
			if (emit) begin
				verdict_d = 1'b1;
			end
		end
		// end of area returns everything to its reset value
		if (last_s1) begin
			phase_d   = PH_KIND;
			left_d    = '0;
			capt_d    = 1'b0;
			stamps_d  = '0;
			verdict_d = 1'b0;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			byte_s1 <= opt_byte;
			last_s1 <= last_byte;
		end
	end

	// parse state update, one item per advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_KIND;
			left_q    <= '0;
			capt_q    <= 1'b0;
			stamps_q  <= '0;
			verdict_q <= 1'b0;
		end else if (advance && valid_s1) begin
			phase_q   <= phase_d;
			left_q    <= left_d;
			capt_q    <= capt_d;
			stamps_q  <= stamps_d;
			verdict_q <= verdict_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			res_status_q <= emit_status;
			if (emit_status == ST_FOUND) begin
				res_val_q <= shifted[63:32];
				res_ecr_q <= shifted[31:0];
			end else begin
				res_val_q <= '0;
				res_ecr_q <= '0;
			end
		end
	end

	assign out_valid = res_valid_q;
	assign status    = res_status_q;
	assign ts_value  = res_val_q;
	assign ts_echo   = res_ecr_q;

endmodule

[verif/tb_tcp_timestamp_option_finder_unit.sv]
// ----------------------------------------------------------------------------
// tb_tcp_timestamp_option_finder_unit
// Self-checking bench for the TCP timestamp option finder. Options areas are
// fed one byte per item. A tracker predicts each area's single verdict and
// checks every result against it, field by field. The directed areas come
// first, then random areas: mostly well-formed option lists, some broken
// ones and some noise. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_tcp_timestamp_option_finder_unit;
	import tsof_pkg::*;

	localparam int unsigned RANDOM_ITEMS  = 1900;
	localparam int unsigned QUIET_LIMIT   = 2000;
	localparam int unsigned DRAIN_CYCLES  = 8;

	typedef struct {
		status_t st;
		stamp_t  val;
		stamp_t  ecr;
	} verdict_t;

	// predicts the verdict of each area and checks results in order
	class verdict_tracker;
		verdict_t    expected_verdicts[$];
		int unsigned fail_count;
		phase_t      phase;
		logic [7:0]  body_left;
		bit          ts_option;
		logic [63:0] stamps;
		bit          verdict_out;

		function new();
			fail_count = 0;
			clear_area();
		endfunction

		function void clear_area();
			phase       = PH_KIND;
			body_left   = 8'd0;
			ts_option   = 1'b0;
			stamps      = 64'd0;
			verdict_out = 1'b0;
		endfunction

		function void post_verdict(status_t st, stamp_t val, stamp_t ecr);
			verdict_t v;
			v.st  = st;
			v.val = val;
			v.ecr = ecr;
			expected_verdicts.push_back(v);
			verdict_out = 1'b1;
		endfunction

		// one accepted byte of the options area
		function void take_byte(logic [7:0] b, logic last);
			if (!verdict_out) begin
				case (phase)
					PH_LEN: begin
						if (b < HDR_BYTES) begin
							post_verdict(ST_BAD_LEN, '0, '0);
						end else if (b == HDR_BYTES) begin
							phase     = PH_KIND;
							ts_option = 1'b0;
							if (last)
								post_verdict(ST_NONE, '0, '0);
						end else if (last) begin
							post_verdict(ST_BAD_LEN, '0, '0);
						end else begin
							body_left = b - HDR_BYTES;
							ts_option = ts_option && (b == LEN_TSTAMP);
							stamps    = 64'd0;
							phase     = PH_BODY;
						end
					end
					PH_BODY: begin
						stamps = {stamps[55:0], b};
						if (body_left != 8'd0)
							body_left = body_left - 8'd1;
						if (body_left == 8'd0) begin
							phase = PH_KIND;
							if (ts_option)
								post_verdict(ST_FOUND, stamps[63:32], stamps[31:0]);
							else if (last)
								post_verdict(ST_NONE, '0, '0);
							ts_option = 1'b0;
						end else if (last) begin
							post_verdict(ST_BAD_LEN, '0, '0);
						end
					end
					default: begin
						if (b == KIND_EOL) begin
							post_verdict(ST_NONE, '0, '0);
						end else if (b == KIND_NOP) begin
							if (last)
								post_verdict(ST_NONE, '0, '0);
						end else if (last) begin
							post_verdict(ST_CUT, '0, '0);
						end else begin
							ts_option = (b == KIND_TSTAMP);
							phase     = PH_LEN;
						end
					end
				endcase
			end
			if (last)
				clear_area();
		endfunction

		// one accepted result against the oldest prediction
		function void check_verdict(status_t st, stamp_t val, stamp_t ecr);
			verdict_t v;
			if (expected_verdicts.size() == 0) begin
				$display("%0t: unexpected verdict status %0d ts_value %h ts_echo %h",
					$time, st, val, ecr);
				fail_count++;
			end else begin
				v = expected_verdicts.pop_front();
				if (st !== v.st) begin
					$display("%0t: status expected %0d got %0d", $time, v.st, st);
					fail_count++;
				end
				if (val !== v.val) begin
					$display("%0t: ts_value expected %h got %h", $time, v.val, val);
					fail_count++;
				end
				if (ecr !== v.ecr) begin
					$display("%0t: ts_echo expected %h got %h", $time, v.ecr, ecr);
					fail_count++;
				end
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] opt_byte;
	logic       last_byte;
	logic       out_valid;
	logic       out_stall;
	status_t    status;
	stamp_t     ts_value;
	stamp_t     ts_echo;

	verdict_tracker tracker = new();

	logic [7:0]  area_q[$];
	int unsigned items_sent;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned quiet_cycles;

	tcp_timestamp_option_finder_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opt_byte  (opt_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.ts_value  (ts_value),
		.ts_echo   (ts_echo)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver stalls at random
	initial begin
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles = quiet_cycles + 1;
			if (in_valid && !in_stall) begin
				tracker.take_byte(opt_byte, last_byte);
				quiet_cycles = 0;
			end
			if (out_valid && !out_stall) begin
				tracker.check_verdict(status, ts_value, ts_echo);
				quiet_cycles = 0;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// feed area_q as one options area, last mark on its final byte
	task send_area;
		int i;
		for (i = 0; i < area_q.size(); i++) begin
			while ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
			in_valid  <= 1'b1;
			opt_byte  <= area_q[i];
			last_byte <= (i == area_q.size() - 1);
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			@(negedge clk);
			items_sent++;
		end
	endtask

	// stimulus
	initial begin
		int unsigned sel;
		int unsigned n_opts;
		int unsigned pick;
		int unsigned len;
		int unsigned idx;
		logic [7:0]  kind;
		bit          ended;

		arst_n         = 1'b0;
		in_valid       = 1'b0;
		opt_byte       = 8'd0;
		last_byte      = 1'b0;
		out_stall      = 1'b0;
		items_sent     = 0;
		quiet_cycles   = 0;
		send_idle_pct  = 7;
		recv_stall_pct = 61;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed areas
		area_q = '{KIND_EOL};
		send_area();
		area_q = '{KIND_NOP};
		send_area();
		area_q = '{KIND_TSTAMP};
		send_area();
		area_q = '{8'd255};
		send_area();
		// length below 2, later bytes dropped
		area_q = '{8'd5, 8'd1, 8'd7};
		send_area();
		area_q = '{8'd9, 8'd0};
		send_area();
		// ends on an option boundary
		area_q = '{8'd2, HDR_BYTES};
		send_area();
		// runs past the area on the length byte and in the body
		area_q = '{8'd4, 8'd255};
		send_area();
		area_q = '{8'd3, 8'd5, 8'd9, 8'd9};
		send_area();
		// timestamp with extreme stamps, verdict on the last byte
		area_q = '{KIND_NOP, KIND_TSTAMP, LEN_TSTAMP, 8'hff, 8'hff, 8'hff, 8'hff,
			8'h00, 8'h00, 8'h00, 8'h00};
		send_area();

		// random areas in three idling regimes
		while (items_sent < RANDOM_ITEMS + 25) begin
			if (items_sent > 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end else if (items_sent > RANDOM_ITEMS / 3) begin
				send_idle_pct  = 61;
				recv_stall_pct = 7;
			end
			area_q.delete();
			sel = $urandom_range(99);
			if (sel < 90) begin
				// well-formed option list
				n_opts = $urandom_range(1, 6);
				ended  = 1'b0;
				while (n_opts > 0 && !ended) begin
					n_opts--;
					pick = $urandom_range(9);
					if (pick < 2) begin
						area_q.push_back(KIND_NOP);
					end else if (pick < 5) begin
						area_q.push_back(KIND_TSTAMP);
						area_q.push_back(LEN_TSTAMP);
						repeat (8) area_q.push_back(8'($urandom_range(255)));
					end else if (pick < 9) begin
						if (pick == 5) begin
							kind = KIND_TSTAMP;
							len  = $urandom_range(2, 13);
							if (len == LEN_TSTAMP)
								len = 11;
						end else begin
							kind = 8'($urandom_range(2, 255));
							if (kind == KIND_TSTAMP)
								kind = 8'd9;
							len = $urandom_range(2, 12);
						end
						area_q.push_back(kind);
						area_q.push_back(8'(len));
						repeat (len - 2) area_q.push_back(8'($urandom_range(255)));
					end else begin
						area_q.push_back(KIND_EOL);
						repeat ($urandom_range(3)) area_q.push_back(8'($urandom_range(255)));
						ended = 1'b1;
					end
				end
				// broken lists: cut short or one byte replaced
				if (sel >= 75) begin
					if ($urandom_range(1)) begin
						idx    = $urandom_range(area_q.size() - 1);
						area_q = area_q[0:idx];
					end else begin
						idx  = $urandom_range(area_q.size() - 1);
						pick = $urandom_range(3);
						case (pick)
							0:       area_q[idx] = 8'd0;
							1:       area_q[idx] = 8'd1;
							2:       area_q[idx] = 8'd255;
							default: area_q[idx] = 8'($urandom_range(255));
						endcase
					end
				end
			end else begin
				// noise
				repeat ($urandom_range(1, 12)) area_q.push_back(8'($urandom_range(255)));
			end
			send_area();
		end
		in_valid <= 1'b0;

		// drain the outstanding verdicts
		while (tracker.expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
design/tsof_pkg.sv
design/tcp_timestamp_option_finder_unit.sv
verif/tb_tcp_timestamp_option_finder_unit.sv
